FILE: src/pwsd_pkg.sv
// shared types and constants for the plane-wave steering delay block
package pwsd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned EdgeW = 12;
  localparam int unsigned SpmW = 16;
  localparam int unsigned DistW = 17;
  localparam int unsigned QuotW = 32;
  localparam int unsigned RootW = 16;
  localparam int unsigned FacW = 17;

  localparam logic [CfgIdxW-1:0] CfgEdgeOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSamplesPerMm = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam logic [EdgeW-1:0] EdgeReset = 12'd430;
  localparam logic [SpmW-1:0] SpmReset = 16'd2980;

  typedef struct packed {
    logic inv;
    logic ay_zero;
    logic [DistW-1:0] span;
  } side_t;

endpackage

FILE: src/pwsd_if.sv
// item channels: input item and result item
interface pwsd_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] mic_x;
  modport source (output valid, target_x, target_y, mic_x, input ready);
  modport sink (input valid, target_x, target_y, mic_x, output ready);
endinterface

interface pwsd_out_if;
  logic valid;
  logic ready;
  logic [7:0] delay_samples;
  logic invalid_target;
  modport source (output valid, delay_samples, invalid_target, input ready);
  modport sink (input valid, delay_samples, invalid_target, output ready);
endinterface

FILE: src/plane_wave_steering_delay_top.sv
// top level of the plane-wave steering delay block
// use: one item per microphone on in_i carries the target position and the
// microphone x position; one result item on out_o carries the delay in
// samples, rounded and saturated at 255, and a flag for a target at origin.
// both channels use valid/ready; an item moves when both are high.
// configuration: cfg_we_i with cfg_idx_i 0 writes the edge offset in mm,
// index 1 the samples per mm in q16; write only while the block is idle.
// throughput: one item per cycle, sustained unless the output queue stalls the pipeline.
// pipeline: 2 front stages, 33 divider stages (an input stage, then one
// quotient bit each), 17 square root stages (an input stage, then one root
// bit each) and 3 multiply and round stages, then a 2-entry queue.
// reset: pipeline and queue empty, edge offset 430, samples per mm 2980.
// stall: results collect in the output queue; the pipeline holds in place
// only when its last stage holds an item and the queue is full, so nothing
// is lost or repeated and in_i.ready drops for that cycle.
module plane_wave_steering_delay_top import pwsd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  pwsd_in_if.sink              in_i,
  pwsd_out_if.source           out_o
);

  logic [EdgeW-1:0] edge_q;
  logic [SpmW-1:0]  spm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= EdgeReset;
      spm_q  <= SpmReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEdgeOffset:   edge_q <= cfg_data_i[EdgeW-1:0];
        CfgSamplesPerMm: spm_q  <= cfg_data_i[SpmW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic take;
  assign take = in_i.valid && in_i.ready;

  // front: magnitudes, edge side, distance
  logic [15:0]       ax, ay;
  logic              neg_edge;
  logic signed [17:0] edge_s, diff_s;
  side_t             side_in;

  assign ax = in_i.target_x[15] ? 16'(-in_i.target_x) : 16'(in_i.target_x);
  assign ay = in_i.target_y[15] ? 16'(-in_i.target_y) : 16'(in_i.target_y);
  assign neg_edge = (in_i.target_x != '0) && (in_i.target_y != '0)
                    && (in_i.target_x[15] != in_i.target_y[15]);
  assign edge_s = neg_edge ? -$signed({6'd0, edge_q}) : $signed({6'd0, edge_q});
  assign diff_s = edge_s - 18'(in_i.mic_x);
  assign side_in.inv     = (in_i.target_x == '0) && (in_i.target_y == '0);
  assign side_in.ay_zero = (in_i.target_y == '0);
  assign side_in.span    = diff_s[17] ? 17'(-diff_s) : 17'(diff_s);

  logic        va_q, vb_q;
  logic [15:0] ax_q, ay_q;
  logic [30:0] ax2_q, ay2_q;
  side_t       sa_q, sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= take;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= ax;
      ay_q  <= ay;
      sa_q  <= side_in;
      ax2_q <= 31'({16'd0, ax_q} * {16'd0, ax_q});
      ay2_q <= 31'({16'd0, ay_q} * {16'd0, ay_q});
      sb_q  <= sa_q;
    end
  end

  logic              vd;
  logic [QuotW-1:0]  quot;
  side_t             sd;

  pwsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (vb_q),
    .num_i  (ax2_q),
    .den_i  ({1'b0, ax2_q} + {1'b0, ay2_q}),
    .side_i (sb_q),
    .v_o    (vd),
    .quot_o (quot),
    .side_o (sd)
  );

  logic              vs;
  logic [RootW-1:0]  root;
  side_t             ss;

  pwsd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (vd),
    .x_i    (quot),
    .side_i (sd),
    .v_o    (vs),
    .root_o (root),
    .side_o (ss)
  );

  logic       v_last;
  logic [7:0] dly;
  logic       inv;

  pwsd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .v_i     (vs),
    .root_i  (root),
    .side_i  (ss),
    .spm_i   (spm_q),
    .v_o     (v_last),
    .delay_o (dly),
    .inv_o   (inv)
  );

  // output queue
  logic [8:0] q_mem [0:1];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       full, push, pop;

  assign full = cnt_q == 2'd2;
  assign en   = !v_last || !full;
  assign push = en && v_last;
  assign pop  = out_o.valid && out_o.ready;

  assign in_i.ready          = en;
  assign out_o.valid         = cnt_q != 2'd0;
  assign out_o.delay_samples = q_mem[rp_q][7:0];
  assign out_o.invalid_target = q_mem[rp_q][8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= {inv, dly};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("output queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("push into full queue");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni) !en |-> v_last)
    else $error("pipeline stalled without a waiting item");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && out_o.invalid_target) |-> (out_o.delay_samples == 8'd0))
    else $error("invalid target with nonzero delay");

endmodule

FILE: src/pwsd_div.sv
// pipelined restoring divider, one quotient bit per stage
module pwsd_div import pwsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  logic [30:0]       num_i,
  input  logic [31:0]       den_i,
  input  side_t             side_i,
  output logic              v_o,
  output logic [QuotW-1:0]  quot_o,
  output side_t             side_o
);

  logic              v_q    [0:QuotW];
  logic [31:0]       rem_q  [0:QuotW-1];
  logic [31:0]       den_q  [0:QuotW-1];
  logic [QuotW-1:0]  quot_q [0:QuotW];
  side_t             side_q [0:QuotW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, num_i};
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [32:0] shl;
    logic        ge;
    assign shl  = {rem_q[k], 1'b0};
    assign ge   = shl >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[k+1] <= {quot_q[k][QuotW-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end

    if (k < QuotW - 1) begin : g_carry
      logic [32:0] diff;
      assign diff = shl - {1'b0, den_q[k]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[31:0] : shl[31:0];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign v_o    = v_q[QuotW];
  assign quot_o = quot_q[QuotW];
  assign side_o = side_q[QuotW];

endmodule

FILE: src/pwsd_sqrt.sv
// pipelined integer square root, one result bit per stage
module pwsd_sqrt import pwsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  logic [QuotW-1:0]  x_i,
  input  side_t             side_i,
  output logic              v_o,
  output logic [RootW-1:0]  root_o,
  output side_t             side_o
);

  logic              v_q    [0:RootW];
  logic [31:0]       rem_q  [0:RootW-1];
  logic [RootW-1:0]  res_q  [0:RootW];
  side_t             side_q [0:RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= x_i;
      res_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int unsigned B = RootW - 1 - k;
    logic [33:0] trial;
    logic        ge;
    assign trial = ({18'd0, res_q[k]} << (B + 1)) + (34'd1 << (2 * B));
    assign ge    = {2'b00, rem_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[k+1]  <= ge ? (res_q[k] | (RootW'(1) << B)) : res_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    if (k < RootW - 1) begin : g_carry
      logic [33:0] diff;
      assign diff = {2'b00, rem_q[k]} - trial;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[31:0] : rem_q[k];
        end
      end
    end
  end

  assign v_o    = v_q[RootW];
  assign root_o = res_q[RootW];
  assign side_o = side_q[RootW];

endmodule

FILE: src/pwsd_scale.sv
// scaling multiplies, rounding and saturation
module pwsd_scale import pwsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              v_i,
  input  logic [RootW-1:0]  root_i,
  input  side_t             side_i,
  input  logic [SpmW-1:0]   spm_i,
  output logic              v_o,
  output logic [7:0]        delay_o,
  output logic              inv_o
);

  logic [FacW-1:0] fac;
  logic            v1_q, v2_q, v3_q;
  logic [33:0]     p1_q;
  logic [49:0]     p2_q;
  logic            inv1_q, inv2_q, inv3_q;
  logic [7:0]      dly_q;
  logic [50:0]     rnd;
  logic [18:0]     whole;

  assign fac   = side_i.ay_zero ? (FacW'(1) << RootW) : {1'b0, root_i};
  assign rnd   = {1'b0, p2_q} + (51'd1 << 31);
  assign whole = rnd[50:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= {17'd0, side_i.span} * {17'd0, fac};
      inv1_q <= side_i.inv;
      p2_q   <= {16'd0, p1_q} * {34'd0, spm_i};
      inv2_q <= inv1_q;
      inv3_q <= inv2_q;
      if (inv2_q) begin
        dly_q <= '0;
      end else if (whole > 19'd255) begin
        dly_q <= 8'hFF;
      end else begin
        dly_q <= whole[7:0];
      end
    end
  end

  assign v_o     = v3_q;
  assign delay_o = dly_q;
  assign inv_o   = inv3_q;

endmodule
